/* design/rcrq_pkg.sv */
// Shared types and constants for the read completion reorder queue.
`default_nettype none

package rcrq_pkg;

  // Field widths of one word on either side
  localparam int unsigned ID_W     = 64;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned OPCODE_W = 4;

  // Most completions drained for one response
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned POP_W       = $clog2(MAX_RESULTS + 1);

  // RDMAP opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE     = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_READ_RESP = 4'd2;

  // Per-entry completion flag
  localparam logic ENTRY_PENDING  = 1'b0;
  localparam logic ENTRY_COMPLETE = 1'b1;

  // Input word kinds
  localparam logic ACT_POST   = 1'b0;
  localparam logic ACT_TAGGED = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_OP  = 2'd1,
    STAT_BAD_MSG = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic                action;
    logic [ID_W-1:0]     work_id;
    logic [TAG_W-1:0]    steering_tag;
    logic [OPCODE_W-1:0] opcode;
    logic [LEN_W-1:0]    msg_length;
  } in_t;

  typedef struct packed {
    logic             has_completion;
    status_e          status;
    logic [ID_W-1:0]  done_id;
    logic [LEN_W-1:0] done_length;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

/* design/rcrq_mem.sv */
// Simple dual-port synchronous memory with registered read data.
`default_nettype none

module rcrq_mem #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/rcrq_ctrl.sv */
// Queue sequencer: post, tag scan over the entry memory, in-order drain.
`default_nettype none

module rcrq_ctrl
  import rcrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Input words
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire in_t                     in_data_i,
  // Configuration
  input  wire logic                    cfg_en_i,
  // Result push toward the output register
  input  wire logic                    out_room_i,
  output logic                         push_o,
  output res_t                         res_o,
  // Entry memory: {work id, tag}
  output logic                         ent_we_o,
  output logic [AW-1:0]                ent_waddr_o,
  output logic [ID_W+TAG_W-1:0]        ent_wdata_o,
  output logic                         ent_re_o,
  output logic [AW-1:0]                ent_raddr_o,
  input  wire logic [ID_W+TAG_W-1:0]   ent_rdata_i,
  // Length memory
  output logic                         len_we_o,
  output logic [AW-1:0]                len_waddr_o,
  output logic [LEN_W-1:0]             len_wdata_o,
  output logic                         len_re_o,
  output logic [AW-1:0]                len_raddr_o,
  input  wire logic [LEN_W-1:0]        len_rdata_i
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DECIDE    = 6'b000010,
    S_SCAN      = 6'b000100,
    S_DRAIN_CHK = 6'b001000,
    S_DRAIN_RD  = 6'b010000,
    S_EMIT      = 6'b100000
  } state_e;

  function automatic res_t status_only(status_e st);
    res_t r;
    r.has_completion = 1'b0;
    r.status         = st;
    r.done_id        = '0;
    r.done_length    = '0;
    r.last           = 1'b1;
    return r;
  endfunction

  function automatic logic [AW-1:0] next_slot(logic [AW-1:0] s);
    return (s == AW'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  state_e               state_q, state_d, ret_q, ret_d;
  in_t                  in_q;
  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [QUEUE_DEPTH-1:0] done_q, done_d;
  logic [AW-1:0]        scan_slot_q, scan_slot_d;
  logic [CW-1:0]        scan_left_q, scan_left_d;
  logic                 found_q, found_d;
  logic [POP_W-1:0]     pops_q, pops_d;
  logic                 more_q, more_d;
  res_t                 res_q, res_d;

  logic                 emit_req;
  res_t                 emit_res;
  state_e               emit_ret;
  logic [AW:0]          tail_sum;
  logic [AW-1:0]        tail;
  logic                 tag_hit;
  logic                 found_now;
  logic                 pop_ok;
  logic [AW-1:0]        head_nxt;

  // Slot just past the last entry
  assign tail_sum = {1'b0, head_q} + (AW+1)'(count_q);
  assign tail     = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];

  assign tag_hit   = (ent_rdata_i[TAG_W-1:0] == in_q.steering_tag);
  assign found_now = found_q | tag_hit;
  assign head_nxt  = next_slot(head_q);
  assign pop_ok    = (count_q != '0) && (pops_q < POP_W'(MAX_RESULTS)) &&
                     (done_q[head_q] == ENTRY_COMPLETE);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    head_d      = head_q;
    count_d     = count_q;
    done_d      = done_q;
    scan_slot_d = scan_slot_q;
    scan_left_d = scan_left_q;
    found_d     = found_q;
    pops_d      = pops_q;
    more_d      = more_q;
    res_d       = res_q;

    emit_req = 1'b0;
    emit_res = status_only(STAT_OK);
    emit_ret = S_IDLE;

    push_o = 1'b0;
    res_o  = res_q;

    ent_we_o    = 1'b0;
    ent_waddr_o = tail;
    ent_wdata_o = {in_q.work_id, in_q.steering_tag};
    ent_re_o    = 1'b0;
    ent_raddr_o = head_q;
    len_we_o    = 1'b0;
    len_waddr_o = scan_slot_q;
    len_wdata_o = in_q.msg_length;
    len_re_o    = 1'b0;
    len_raddr_o = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECIDE;
        end
      end

      // Classify the word; append a post, answer a write or an error, or start the tag scan
      S_DECIDE: begin
        pops_d  = '0;
        found_d = 1'b0;
        priority if (in_q.action == ACT_POST) begin
          emit_req = 1'b1;
          if (count_q == CW'(QUEUE_DEPTH)) begin
            emit_res = status_only(STAT_FULL);
          end else begin
            ent_we_o     = 1'b1;
            done_d[tail] = ENTRY_PENDING;
            count_d      = count_q + 1'b1;
            emit_res     = status_only(STAT_OK);
          end
        end else if (in_q.opcode == OP_WRITE) begin
          emit_req = 1'b1;
          emit_res = status_only(STAT_OK);
        end else if (in_q.opcode != OP_READ_RESP) begin
          emit_req = 1'b1;
          emit_res = status_only(STAT_BAD_OP);
        end else if (count_q == '0) begin
          emit_req = 1'b1;
          emit_res = status_only(STAT_BAD_MSG);
        end else begin
          ent_re_o    = 1'b1;
          ent_raddr_o = head_q;
          scan_slot_d = head_q;
          scan_left_d = count_q;
          state_d     = S_SCAN;
        end
      end

      // Compare one stored tag a cycle; the next read is issued alongside
      S_SCAN: begin
        if (tag_hit) begin
          done_d[scan_slot_q] = ENTRY_COMPLETE;
          len_we_o            = 1'b1;
        end
        found_d     = found_now;
        scan_left_d = scan_left_q - 1'b1;
        if (scan_left_q == CW'(1)) begin
          if (found_now) begin
            state_d = S_DRAIN_CHK;
          end else begin
            emit_req = 1'b1;
            emit_res = status_only(STAT_BAD_MSG);
          end
        end else begin
          ent_re_o    = 1'b1;
          ent_raddr_o = next_slot(scan_slot_q);
          scan_slot_d = next_slot(scan_slot_q);
        end
      end

      // Pop the head if complete and look ahead for another pop
      S_DRAIN_CHK: begin
        if (pop_ok) begin
          ent_re_o       = 1'b1;
          len_re_o       = 1'b1;
          done_d[head_q] = ENTRY_PENDING;
          head_d         = head_nxt;
          count_d        = count_q - 1'b1;
          pops_d         = pops_q + 1'b1;
          more_d         = (count_q > CW'(1)) &&
                           (pops_q < POP_W'(MAX_RESULTS - 1)) &&
                           (done_q[head_nxt] == ENTRY_COMPLETE);
          state_d        = S_DRAIN_RD;
        end else begin
          emit_req = 1'b1;
          emit_res = status_only(STAT_OK);
        end
      end

      // Build the completion from the popped entry when completions are enabled
      S_DRAIN_RD: begin
        if (cfg_en_i) begin
          emit_req                = 1'b1;
          emit_res.has_completion = 1'b1;
          emit_res.status         = STAT_OK;
          emit_res.done_id        = ent_rdata_i[ID_W+TAG_W-1:TAG_W];
          emit_res.done_length    = len_rdata_i;
          emit_res.last           = !more_q;
          emit_ret                = more_q ? S_DRAIN_CHK : S_IDLE;
        end else if (more_q) begin
          state_d = S_DRAIN_CHK;
        end else begin
          emit_req = 1'b1;
          emit_res = status_only(STAT_OK);
        end
      end

      // Hold a parked result until the output register frees
      S_EMIT: begin
        if (out_room_i) begin
          push_o  = 1'b1;
          res_o   = res_q;
          state_d = ret_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Hand a result to the output register or park it
    if (emit_req) begin
      if (out_room_i) begin
        push_o  = 1'b1;
        res_o   = emit_res;
        state_d = emit_ret;
      end else begin
        res_d   = emit_res;
        ret_d   = emit_ret;
        state_d = S_EMIT;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      done_q      <= '0;
      scan_slot_q <= '0;
      scan_left_q <= '0;
      found_q     <= 1'b0;
      pops_q      <= '0;
      more_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      head_q      <= head_d;
      count_q     <= count_d;
      done_q      <= done_d;
      scan_slot_q <= scan_slot_d;
      scan_left_q <= scan_left_d;
      found_q     <= found_d;
      pops_q      <= pops_d;
      more_q      <= more_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_room_i)
    else $error("result pushed into occupied output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_left_q != '0))
    else $error("tag scan running with nothing left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN_CHK && pops_q != '0) |-> pop_ok)
    else $error("drain resumed without a completed head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !res_o.last) |-> res_o.has_completion)
    else $error("status-only result not marked last");

endmodule

`default_nettype wire

/* design/read_completion_reorder_queue.sv */
// A post, a write, or an error is classified in the decide state, which hands on its result.
// A read response first compares the tag of every queued entry in the entry memory,
// then pops completed entries from the head through a check and a read state.
// Throughput: one word at a time; the next word is taken once the last result
// of the previous one sits in the output register.
// Reset clears pointers, count, completion flags and sets completions enabled.
`default_nettype none

module read_completion_reorder_queue
  import rcrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input words
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // work_id, steering_tag, msg_length
  input  wire logic [4:0]   s_axis_tuser,  // action, opcode
  // Result words
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,  // done_id, done_length
  output logic [2:0]        m_axis_tuser,  // has_completion, status
  output logic              m_axis_tlast,
  // Configuration write
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_data_i     // completions_enabled
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  in_t                    in_data;
  res_t                   res;
  logic                   push;
  logic                   out_room;
  logic                   out_valid_q;
  res_t                   out_q;
  logic                   cfg_en_q;

  logic                   ent_we, ent_re, len_we, len_re;
  logic [AW-1:0]          ent_waddr, ent_raddr, len_waddr, len_raddr;
  logic [ID_W+TAG_W-1:0]  ent_wdata, ent_rdata;
  logic [LEN_W-1:0]       len_wdata, len_rdata;

  // Unpack the input word
  assign in_data.action       = s_axis_tuser[0];
  assign in_data.opcode       = s_axis_tuser[4:1];
  assign in_data.work_id      = s_axis_tdata[63:0];
  assign in_data.steering_tag = s_axis_tdata[95:64];
  assign in_data.msg_length   = s_axis_tdata[127:96];

  // Configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      cfg_en_q <= cfg_data_i;
    end
  end

  rcrq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_data),
    .cfg_en_i    (cfg_en_q),
    .out_room_i  (out_room),
    .push_o      (push),
    .res_o       (res),
    .ent_we_o    (ent_we),
    .ent_waddr_o (ent_waddr),
    .ent_wdata_o (ent_wdata),
    .ent_re_o    (ent_re),
    .ent_raddr_o (ent_raddr),
    .ent_rdata_i (ent_rdata),
    .len_we_o    (len_we),
    .len_waddr_o (len_waddr),
    .len_wdata_o (len_wdata),
    .len_re_o    (len_re),
    .len_raddr_o (len_raddr),
    .len_rdata_i (len_rdata)
  );

  rcrq_mem #(
    .WIDTH (ID_W + TAG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ent_mem (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  rcrq_mem #(
    .WIDTH (LEN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_len_mem (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .re_i    (len_re),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // Output register: load on push, drop when taken
  assign out_room = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.done_length, out_q.done_id};
  assign m_axis_tuser  = {out_q.status, out_q.has_completion};
  assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire

/* verif/rcrq_checker.sv */
// Scoreboard for the read completion reorder queue: predicts and checks results.
module rcrq_checker
  import rcrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // work_id, steering_tag, msg_length
  input  logic [4:0]   s_axis_tuser,  // action, opcode
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,  // done_id, done_length
  input  logic [2:0]   m_axis_tuser,  // has_completion, status
  input  logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic         cfg_data_i,    // completions_enabled
  output int           errors_o,
  output int           pending_o,
  output int           results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 100;

  // Shadow copy of the outstanding read queue
  logic [ID_W-1:0]  slot_id   [QUEUE_DEPTH];
  logic [TAG_W-1:0] slot_tag  [QUEUE_DEPTH];
  logic             slot_done [QUEUE_DEPTH];
  logic [LEN_W-1:0] slot_len  [QUEUE_DEPTH];
  int unsigned      head_ptr;
  int unsigned      live_count;
  logic             report_en;

  res_t due_results[$];
  in_t  word_in;
  res_t word_out;
  res_t want;

  assign pending_o = due_results.size();

  function automatic res_t status_word(input status_e st);
    res_t r;
    r = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // Advance the shadow queue by one input word and queue what it must produce
  task automatic apply_word_to_queue(input in_t w);
    int unsigned slot;
    int unsigned pops;
    logic        hit;
    logic        have_prev;
    res_t        prev;
    res_t        r;
    pops      = 0;
    hit       = 1'b0;
    have_prev = 1'b0;
    prev      = '0;
    r         = '0;
    if (w.action == ACT_POST) begin
      if (live_count >= QUEUE_DEPTH) begin
        due_results.push_back(status_word(STAT_FULL));
      end else begin
        slot            = (head_ptr + live_count) % QUEUE_DEPTH;
        slot_id[slot]   = w.work_id;
        slot_tag[slot]  = w.steering_tag;
        slot_done[slot] = ENTRY_PENDING;
        slot_len[slot]  = '0;
        live_count++;
        due_results.push_back(status_word(STAT_OK));
      end
    end else if (w.opcode == OP_WRITE) begin
      due_results.push_back(status_word(STAT_OK));
    end else if (w.opcode != OP_READ_RESP) begin
      due_results.push_back(status_word(STAT_BAD_OP));
    end else if (live_count == 0) begin
      due_results.push_back(status_word(STAT_BAD_MSG));
    end else begin
      // Mark every queued entry carrying this tag
      for (int unsigned k = 0; k < live_count; k++) begin
        slot = (head_ptr + k) % QUEUE_DEPTH;
        if (slot_tag[slot] == w.steering_tag) begin
          hit             = 1'b1;
          slot_done[slot] = ENTRY_COMPLETE;
          slot_len[slot]  = w.msg_length;
        end
      end
      if (!hit) begin
        due_results.push_back(status_word(STAT_BAD_MSG));
      end else begin
        // Drain completed entries from the head in issue order
        while (live_count > 0 && pops < MAX_RESULTS &&
               slot_done[head_ptr] == ENTRY_COMPLETE) begin
          if (report_en) begin
            if (have_prev) due_results.push_back(prev);
            r.has_completion = 1'b1;
            r.status         = STAT_OK;
            r.done_id        = slot_id[head_ptr];
            r.done_length    = slot_len[head_ptr];
            r.last           = 1'b0;
            prev             = r;
            have_prev        = 1'b1;
          end
          slot_done[head_ptr] = ENTRY_PENDING;
          head_ptr            = (head_ptr + 1) % QUEUE_DEPTH;
          live_count--;
          pops++;
        end
        if (have_prev) begin
          prev.last = 1'b1;
          due_results.push_back(prev);
        end else begin
          due_results.push_back(status_word(STAT_OK));
        end
      end
    end
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < QUEUE_DEPTH; k++) begin
        slot_id[k]   = '0;
        slot_tag[k]  = '0;
        slot_done[k] = ENTRY_PENDING;
        slot_len[k]  = '0;
      end
      head_ptr   = 0;
      live_count = 0;
      report_en  = 1'b1;
      due_results.delete();
      errors_o   = 0;
      results_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) report_en = cfg_data_i;

      // Check a result word against the oldest one owed
      if (m_axis_tvalid && m_axis_tready) begin
        word_out.has_completion = m_axis_tuser[0];
        word_out.status         = status_e'(m_axis_tuser[2:1]);
        word_out.done_id        = m_axis_tdata[63:0];
        word_out.done_length    = m_axis_tdata[95:64];
        word_out.last           = m_axis_tlast;
        results_o++;
        if (due_results.size() == 0) begin
          errors_o++;
          if (errors_o <= MAX_REPORTS)
            $display("%0t: unexpected result has=%0b st=%0d id=%h len=%h last=%0b",
                     $time, word_out.has_completion, word_out.status,
                     word_out.done_id, word_out.done_length, word_out.last);
        end else begin
          want = due_results.pop_front();
          if (word_out.has_completion != want.has_completion ||
              word_out.status != want.status ||
              word_out.done_id != want.done_id ||
              word_out.done_length != want.done_length ||
              word_out.last != want.last) begin
            errors_o++;
            if (errors_o <= MAX_REPORTS)
              $display("%0t: mismatch expected has=%0b st=%0d id=%h len=%h last=%0b",
                       $time, want.has_completion, want.status, want.done_id,
                       want.done_length, want.last,
                       " actual has=%0b st=%0d id=%h len=%h last=%0b",
                       word_out.has_completion, word_out.status, word_out.done_id,
                       word_out.done_length, word_out.last);
          end
        end
      end

      // Predict for an accepted input word
      if (s_axis_tvalid && s_axis_tready) begin
        word_in.action       = s_axis_tuser[0];
        word_in.opcode       = s_axis_tuser[4:1];
        word_in.work_id      = s_axis_tdata[63:0];
        word_in.steering_tag = s_axis_tdata[95:64];
        word_in.msg_length   = s_axis_tdata[127:96];
        apply_word_to_queue(word_in);
      end
    end
  end

endmodule

/* verif/tb.sv */
// Stimulus and verdict for the read completion reorder queue.
module tb
  import rcrq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned POOL_SIZE   = 6;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [4:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic         cfg_data_i;

  int errors;
  int pending;
  int results;

  // Stimulus controls
  logic             gaps_on;
  int               hold_seq;
  int               hold_seen;
  int               words_sent;
  int               stall_cycles;
  int               settings_run;
  logic [TAG_W-1:0] tag_pool [POOL_SIZE];

  read_completion_reorder_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  rcrq_checker #(.QUEUE_DEPTH(DEPTH)) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending),
    .results_o     (results)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random backpressure, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_seen     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen     = hold_seq;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready = gaps_on ? ($urandom_range(99) >= 31) : 1'b1;
    end
  end

  // Abort when no word moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one input word, optionally after a random gap; called at a falling edge
  task automatic send_word(input in_t w);
    if (gaps_on && $urandom_range(99) < 31) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {w.msg_length, w.steering_tag, w.work_id};
    s_axis_tuser  = {w.opcode, w.action};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic post_read(input logic [ID_W-1:0] id, input logic [TAG_W-1:0] tag);
    in_t w;
    w.action       = ACT_POST;
    w.work_id      = id;
    w.steering_tag = tag;
    w.opcode       = OPCODE_W'($urandom_range(15));
    w.msg_length   = $urandom;
    send_word(w);
  endtask

  task automatic tagged_msg(input logic [TAG_W-1:0] tag, input logic [OPCODE_W-1:0] op,
                            input logic [LEN_W-1:0] len);
    in_t w;
    w.action       = ACT_TAGGED;
    w.work_id      = {$urandom, $urandom};
    w.steering_tag = tag;
    w.opcode       = op;
    w.msg_length   = len;
    send_word(w);
  endtask

  // Hold the sender until every owed result has been taken
  task automatic drain_all();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_enable(input logic en);
    drain_all();
    cfg_valid_i = 1'b1;
    cfg_data_i  = en;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    settings_run++;
  endtask

  task automatic refresh_pool(input logic with_extremes);
    for (int k = 0; k < POOL_SIZE; k++) tag_pool[k] = $urandom;
    if (with_extremes) begin
      tag_pool[0] = '0;
      tag_pool[1] = '1;
    end
  endtask

  // One random word: mostly posts and responses to queued tags, some noise
  task automatic random_word();
    int               pick;
    logic [TAG_W-1:0] tag;
    pick = $urandom_range(99);
    tag  = tag_pool[$urandom_range(POOL_SIZE - 1)];
    if (pick < 45) post_read({$urandom, $urandom}, tag);
    else if (pick < 83) tagged_msg(tag, OP_READ_RESP, $urandom);
    else if (pick < 88) tagged_msg($urandom, OP_READ_RESP, $urandom);
    else if (pick < 93) tagged_msg(tag, OP_WRITE, $urandom);
    else tagged_msg(tag, OPCODE_W'($urandom_range(15)), $urandom);
  endtask

  // Random phase; a burst of posts now and then overfills the queue
  task automatic random_phase(input int count, input int quiet_until, input int hold_at);
    int   sent;
    logic held;
    sent = 0;
    held = 1'b0;
    while (sent < count) begin
      gaps_on = (sent >= quiet_until);
      if (!held && hold_at >= 0 && sent >= hold_at) begin
        hold_seq <= hold_seq + 1;
        held = 1'b1;
      end
      if ($urandom_range(99) < 3) begin
        repeat (DEPTH + 2) post_read({$urandom, $urandom},
                                     tag_pool[$urandom_range(POOL_SIZE - 1)]);
        for (int k = 0; k < POOL_SIZE; k++) tagged_msg(tag_pool[k], OP_READ_RESP, $urandom);
        sent += DEPTH + 2 + POOL_SIZE;
      end else begin
        random_word();
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    gaps_on       = 1'b1;
    hold_seq      = 0;
    words_sent    = 0;
    settings_run  = 0;
    stall_cycles  = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_enable(1'b1);

    // Directed: errors on an empty queue, extremes of id and tag, drains
    tagged_msg(32'h0000_0005, OP_READ_RESP, 32'h0000_0010);
    tagged_msg('1, OP_WRITE, '1);
    tagged_msg('0, 4'hF, '0);
    tagged_msg(32'h0000_0005, 4'h1, 32'h1);
    tagged_msg(32'h0000_0005, 4'h8, 32'h1);
    post_read('0, '0);
    post_read('1, '1);
    post_read(64'h0123_4567_89AB_CDEF, '0);
    post_read(64'hFEDC_BA98_7654_3210, 32'h0000_1234);
    // No matching tag
    tagged_msg(32'h0000_DEAD, OP_READ_RESP, 32'h55);
    // Matches an entry behind a pending head: nothing drains
    tagged_msg('1, OP_READ_RESP, 32'h0000_0800);
    // Tag shared by two entries completes both, then three drain at once
    tagged_msg('0, OP_READ_RESP, '1);
    tagged_msg(32'h0000_1234, OP_READ_RESP, '0);
    tagged_msg(32'h0000_1234, OP_READ_RESP, 32'h4);
    tagged_msg(32'h0000_0000, OP_WRITE, 32'h4);

    // Drain with completions disabled, directed
    write_enable(1'b0);
    post_read(64'h1111_2222_3333_4444, 32'h0000_00AA);
    post_read(64'h5555_6666_7777_8888, 32'h0000_00BB);
    tagged_msg(32'h0000_00BB, OP_READ_RESP, 32'h20);
    tagged_msg(32'h0000_00AA, OP_READ_RESP, 32'h30);
    tagged_msg(32'h0000_00AA, 4'h7, 32'h30);

    // Random phases across both settings
    write_enable(1'b1);
    refresh_pool(1'b1);
    random_phase(200, 80, 120);
    write_enable(1'b0);
    refresh_pool(1'b0);
    random_phase(120, 0, -1);
    write_enable(1'b1);
    refresh_pool(1'b0);
    random_phase(150, 0, -1);

    drain_all();
    repeat (60) @(negedge clk_i);

    $display("covered %0d input words under %0d enable settings, %0d result words checked",
             words_sent, settings_run, results);
    $display("posts, full queue, write, bad opcode, unmatched and matched responses exercised");
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results still owed", errors, pending);
      $display("status: fail");
    end
    $finish;
  end

endmodule
